// ===== sv/epmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package epmm_pkg;

   // verdict codes, as reported on rsp_verdict_code
   typedef enum logic [2:0] {
      VC_MARKED       = 3'd0,
      VC_NOT_IPV4     = 3'd1,
      VC_NOT_TCP      = 3'd2,
      VC_TOO_SHORT    = 3'd3,
      VC_PORT_DIFFERS = 3'd4,
      VC_NO_PREFIX    = 3'd5
   } epmm_verdict_type;

   // control register file
   localparam int unsigned CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_TO_MATCH = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_VALUE    = 4'd1;
   localparam logic [15:0] PORT_RESET = 16'd443;
   localparam logic [31:0] MARK_RESET = 32'hFEE1_DEAD;

   // frame layout
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
   localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
   localparam logic [15:0] POS_IHL        = 16'd14;
   localparam logic [15:0] POS_PROTO      = 16'd23;
   localparam logic [15:0] POS_DADDR_FIRST = 16'd30;
   localparam logic [15:0] POS_DADDR_LAST  = 16'd33;
   localparam logic [6:0]  PORT_BASE      = 7'd16;  // 14 + 2
   localparam logic [16:0] LEN_ETH_HDR    = 17'd14;
   localparam logic [16:0] LEN_IP_HDR     = 17'd34;
   localparam logic [6:0]  HDR_BASE       = 7'd34;  // 14 + 20

   // command queue between parser and lookup
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             is_write;
      logic [3:0]       slot;
      logic [31:0]      data;         // prefix for a write, address for a frame
      logic [5:0]       length;
      logic             entry_valid;
      epmm_verdict_type code;         // VC_NO_PREFIX: lookup decides
   } epmm_cmd_type;

   // leading-ones mask; lengths of 32 and above give all ones
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      prefix_mask = ~(32'hFFFF_FFFF >> len);
   endfunction

endpackage
`default_nettype wire

// ===== sv/egress_prefix_match_marker_top.sv =====
// A verdict passes the command queue, hit register and verdict register. Throughput: one
// transaction per cycle on req_ (bytes and table writes alike) until the queue fills, one
// verdict per cycle on rsp_; a 4-entry command queue absorbs response back-pressure.
// Reset (synchronous, active high): all prefix entries invalid, counter zero,
// port_to_match = 443, mark_value = 0xfee1dead, parser at start of frame.
`timescale 1ns / 1ps
`default_nettype none
module egress_prefix_match_marker_top
   import epmm_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // item channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_action,
   input  wire logic [7:0]           req_frame_byte,
   input  wire logic                 req_frame_end,
   input  wire logic [3:0]           req_entry_slot,
   input  wire logic [31:0]          req_entry_prefix,
   input  wire logic [5:0]           req_entry_length,
   input  wire logic                 req_entry_valid,
   // verdict channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_mark_frame,
   output logic [31:0]               rsp_mark_word,
   output logic [2:0]                rsp_verdict_code,
   output logic [63:0]               rsp_marked_total,
   // control register writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   // Front: byte parser. Tracks byte position, captures EtherType, IHL,
   // protocol, destination address and TCP port, and on the last byte
   // pushes a frame command carrying every header check already done;
   // only the prefix lookup is left open. Table writes are pushed as
   // commands too, so they land in order with respect to frames.
   // Back: prefix table, parallel match into a hit register,
   // then the verdict/counter register that drives rsp_.

   logic [15:0]      port_ff;
   logic [31:0]      mark_ff;
   logic             front_cmd_valid;
   logic             queue_push_ready;
   epmm_cmd_type     front_cmd;
   logic             queue_pop_valid;
   logic             back_ready;
   epmm_cmd_type     queue_head;
   epmm_verdict_type back_code;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff <= PORT_RESET;
         mark_ff <= MARK_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PORT_TO_MATCH: begin
               port_ff <= csr_data[15:0];
            end
            CSR_MARK_VALUE: begin
               mark_ff <= csr_data;
            end
            default: begin
               // other indexes: no register, write dropped
            end
         endcase
      end
   end

   epmm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .action        (req_action),
      .frame_byte    (req_frame_byte),
      .frame_end     (req_frame_end),
      .entry_slot    (req_entry_slot),
      .entry_prefix  (req_entry_prefix),
      .entry_length  (req_entry_length),
      .entry_valid   (req_entry_valid),
      .port_to_match (port_ff),
      .cmd_valid     (front_cmd_valid),
      .cmd_ready     (queue_push_ready),
      .cmd_data      (front_cmd)
   );

   epmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_cmd_valid),
      .push_ready (queue_push_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_pop_valid),
      .pop_ready  (back_ready),
      .pop_data   (queue_head)
   );

   epmm_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_pop_valid),
      .cmd_ready        (back_ready),
      .cmd_data         (queue_head),
      .mark_value       (mark_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mark_frame   (rsp_mark_frame),
      .rsp_mark_word    (rsp_mark_word),
      .rsp_verdict_code (back_code),
      .rsp_marked_total (rsp_marked_total)
   );

   assign rsp_verdict_code = back_code;

endmodule
`default_nettype wire

// ===== sv/epmm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module epmm_front
   import epmm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire logic         action,
   input  wire logic [7:0]   frame_byte,
   input  wire logic         frame_end,
   input  wire logic [3:0]   entry_slot,
   input  wire logic [31:0]  entry_prefix,
   input  wire logic [5:0]   entry_length,
   input  wire logic         entry_valid,
   input  wire logic [15:0]  port_to_match,
   output logic              cmd_valid,
   input  wire logic         cmd_ready,
   output epmm_cmd_type      cmd_data
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [31:0] daddr_ff, daddr_in;
   logic [15:0] dport_ff, dport_in;
   logic [6:0]  port_at;
   logic [6:0]  hdr_end;
   logic [16:0] frame_len;
   logic        byte_take;
   epmm_verdict_type pre_code;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid && (action || frame_end);
   assign byte_take = in_valid && cmd_ready && !action;

   always_comb begin
      etype_in = etype_ff;
      ihl_in   = ihl_ff;
      proto_in = proto_ff;
      daddr_in = daddr_ff;
      dport_in = dport_ff;
      port_at  = PORT_BASE + {1'b0, ihl_ff, 2'b00};
      if (pos_ff == POS_ETYPE_HI) begin
         etype_in = {frame_byte, 8'h00};
      end else if (pos_ff == POS_ETYPE_LO) begin
         etype_in = etype_ff | {8'h00, frame_byte};
      end else if (pos_ff == POS_IHL) begin
         ihl_in = frame_byte[3:0];
      end else if (pos_ff == POS_PROTO) begin
         proto_in = frame_byte;
      end
      if (pos_ff >= POS_DADDR_FIRST && pos_ff <= POS_DADDR_LAST) begin
         daddr_in = {daddr_ff[23:0], frame_byte};
      end
      if (pos_ff > POS_IHL && pos_ff == {9'd0, port_at}) begin
         dport_in = {frame_byte, dport_ff[7:0]};
      end else if (pos_ff > POS_IHL && pos_ff == {9'd0, port_at} + 16'd1) begin
         dport_in = {dport_ff[15:8], frame_byte};
      end
      pos_in = (pos_ff == 16'hFFFF) ? pos_ff : pos_ff + 16'd1;
   end

   // header checks in the order they are reported
   always_comb begin
      frame_len = {1'b0, pos_ff} + 17'd1;
      hdr_end   = HDR_BASE + {1'b0, ihl_in, 2'b00};
      if (frame_len < LEN_ETH_HDR) begin
         pre_code = VC_TOO_SHORT;
      end else if (etype_in != ETHERTYPE_IPV4) begin
         pre_code = VC_NOT_IPV4;
      end else if (frame_len < LEN_IP_HDR) begin
         pre_code = VC_TOO_SHORT;
      end else if (proto_in != IP_PROTO_TCP) begin
         pre_code = VC_NOT_TCP;
      end else if (frame_len < {10'd0, hdr_end}) begin
         pre_code = VC_TOO_SHORT;
      end else if (dport_in != port_to_match) begin
         pre_code = VC_PORT_DIFFERS;
      end else begin
         pre_code = VC_NO_PREFIX;
      end
   end

   always_comb begin
      cmd_data.is_write    = action;
      cmd_data.slot        = entry_slot;
      cmd_data.data        = action ? entry_prefix : daddr_in;
      cmd_data.length      = entry_length;
      cmd_data.entry_valid = entry_valid;
      cmd_data.code        = pre_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         etype_ff <= '0;
         proto_ff <= '0;
         ihl_ff   <= '0;
         daddr_ff <= '0;
         dport_ff <= '0;
      end else if (byte_take) begin
         if (frame_end) begin
            pos_ff   <= '0;
            etype_ff <= '0;
            proto_ff <= '0;
            ihl_ff   <= '0;
            daddr_ff <= '0;
            dport_ff <= '0;
         end else begin
            pos_ff   <= pos_in;
            etype_ff <= etype_in;
            proto_ff <= proto_in;
            ihl_ff   <= ihl_in;
            daddr_ff <= daddr_in;
            dport_ff <= dport_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/epmm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module epmm_queue
   import epmm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire epmm_cmd_type  push_data,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output epmm_cmd_type       pop_data
);

   epmm_cmd_type           store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   push_ok;
   logic                   pop_ok;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign push_ok    = push_valid && push_ready;
   assign pop_ok     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== sv/epmm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module epmm_back
   import epmm_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 16
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   output logic               cmd_ready,
   input  wire epmm_cmd_type  cmd_data,
   input  wire logic [31:0]   mark_value,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_mark_frame,
   output logic [31:0]        rsp_mark_word,
   output epmm_verdict_type   rsp_verdict_code,
   output logic [63:0]        rsp_marked_total
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [31:0]              prefix_ff [TABLE_ENTRIES];
   logic [31:0]              mask_ff   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] hit;
   logic [IDX_W-1:0]         slot_idx;
   logic                     table_wr;

   logic                     mid_valid_ff;
   epmm_verdict_type         mid_code_ff;
   logic [TABLE_ENTRIES-1:0] mid_hits_ff;
   logic                     mid_go;
   logic                     mid_free;
   logic                     frame_take;

   logic                     marked;
   logic [63:0]              count_ff;
   logic [63:0]              count_in;
   logic                     rsp_valid_ff;

   assign mid_go     = mid_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign mid_free   = !mid_valid_ff || mid_go;
   // table writes never wait; frames wait for the match stage
   assign cmd_ready  = cmd_data.is_write || mid_free;
   assign frame_take = cmd_valid && !cmd_data.is_write && mid_free;
   assign table_wr   = cmd_valid && cmd_data.is_write &&
                       (32'(cmd_data.slot) < TABLE_ENTRIES);
   assign slot_idx   = IDX_W'(cmd_data.slot);

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit[i] = valid_ff[i] && (((cmd_data.data ^ prefix_ff[i]) & mask_ff[i]) == 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (table_wr) begin
         valid_ff[slot_idx] <= cmd_data.entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (table_wr) begin
         prefix_ff[slot_idx] <= cmd_data.data;
         mask_ff[slot_idx]   <= prefix_mask(cmd_data.length);
      end
   end

   // match stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (frame_take) begin
         mid_valid_ff <= 1'b1;
      end else if (mid_go) begin
         mid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_take) begin
         mid_code_ff <= cmd_data.code;
         mid_hits_ff <= hit;
      end
   end

   // verdict stage
   assign marked   = (mid_code_ff == VC_NO_PREFIX) && (|mid_hits_ff);
   assign count_in = count_ff + {63'd0, marked};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else if (mid_go) begin
         rsp_valid_ff <= 1'b1;
         count_ff     <= count_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_go) begin
         rsp_mark_frame   <= marked;
         rsp_mark_word    <= marked ? mark_value : 32'd0;
         rsp_verdict_code <= marked ? VC_MARKED : mid_code_ff;
         rsp_marked_total <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/epmm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module epmm_checker
   import epmm_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_mark_frame,
   input wire logic [31:0]          rsp_mark_word,
   input wire logic [2:0]           rsp_verdict_code,
   input wire logic [63:0]          rsp_marked_total
);

   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("verdict valid right after reset");

   a_mark_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mark_frame == (rsp_verdict_code == VC_MARKED)))
      else $error("mark flag disagrees with verdict code");

   a_word_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mark_frame) |-> (rsp_mark_word == 32'd0))
      else $error("mark word nonzero on unmarked frame");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_marked_total) && $stable(rsp_verdict_code)))
      else $error("stalled verdict changed");

endmodule

bind egress_prefix_match_marker_top epmm_checker u_epmm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_mark_frame   (rsp_mark_frame),
   .rsp_mark_word    (rsp_mark_word),
   .rsp_verdict_code (rsp_verdict_code),
   .rsp_marked_total (rsp_marked_total)
);
`default_nettype wire
